// ===== rtl/core/wlr_pkg.sv =====
// Shared types and codes for the Wu line rasterizer core.
package wlr_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_MIDDLE,
        PH_FINAL
    } t_phase;

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_PREP,
        ST_DIV,
        ST_GRAD,
        ST_ACC,
        ST_SECOND
    } t_seq_state;

endpackage

// ===== rtl/core/wlr_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, for the gradient.
module wlr_divider #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_dividend,
    input  logic [COORD_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_quotient
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS:0]   r_rem;
    logic [COORD_BITS-1:0] r_div;
    logic [FRAC_BITS:0]    r_quo;

    logic [COORD_BITS+1:0] diff;
    logic                  qbit;
    logic [COORD_BITS:0]   rem_keep;

    // dividend <= divisor, so the remainder left after each subtraction stays below the divisor
    always_comb begin
        diff     = {1'b0, r_rem} - {2'b00, r_div};
        qbit     = !diff[COORD_BITS+1];
        rem_keep = qbit ? diff[COORD_BITS:0] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_keep[COORD_BITS-1:0], 1'b0};
            r_quo <= {r_quo[FRAC_BITS-1:0], qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/wu_line_rasterizer_core.sv =====
// Wu line rasterizer core: endpoint load, gradient division and per-step pixel output.
// A load transaction (tuser 0) orders the endpoints of a sloped line along the major
// axis and runs the divider, one quotient bit per cycle: the core is busy through
// ST_PREP, ST_DIV, ST_GRAD and ST_ACC after the load; axis-aligned and single-point
// lines skip the divider. A step transaction (tuser 1) emits one pixel, or two
// pixels on a middle step, the second from ST_SECOND; the single output register
// sets the pace. The input is taken in ST_ACCEPT while the output register is empty
// or being drained. tlast marks the last pixel of a step, tuser the end of line.
module wu_line_rasterizer_core #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // start_x, start_y, end_x, end_y (low to high), zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]             i_s_tdata,
    // opcode
    input  logic                                          i_s_tuser,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // pixel_x, pixel_y (low to high), zero padded
    output logic [((2*(COORD_BITS+1)+7)/8)*8-1:0]         o_m_tdata,
    // last_of_step
    output logic                                          o_m_tlast,
    // line_done
    output logic                                          o_m_tuser
);
    import wlr_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int PW       = COORD_BITS + 1;
    localparam int GRAD_W   = FRAC_BITS + 2;
    localparam int ACC_W    = COORD_BITS + FRAC_BITS + 2;
    localparam int OUT_W    = 2 * PW;
    localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8;

    t_seq_state r_state, n_state;
    t_phase     r_phase, n_phase;

    logic                     r_x_major, n_x_major;
    logic                     r_axis, n_axis;
    logic                     r_step_down, n_step_down;
    logic [CB-1:0]            r_major_pos, n_major_pos;
    logic [CB-1:0]            r_major_end, n_major_end;
    logic [CB-1:0]            r_minor_start, n_minor_start;
    logic [CB-1:0]            r_minor_end, n_minor_end;
    logic signed [GRAD_W-1:0] r_grad, n_grad;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [CB-1:0]            r_sec_major, n_sec_major;
    logic [PW-1:0]            r_sec_minor, n_sec_minor;

    logic          r_m_tvalid, n_m_tvalid;
    logic [PW-1:0] r_px, n_px;
    logic [PW-1:0] r_py, n_py;
    logic          r_last, n_last;
    logic          r_done, n_done;

    logic [CB-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [CB-1:0] dx, dy;
    logic          load_axis, load_xmaj, x_swap, y_swap;
    logic          out_free, s_acc;

    logic                  div_start, div_done;
    logic [CB-1:0]         div_dividend, div_divisor;
    logic [FRAC_BITS:0]    div_quo;

    logic [PW-1:0]            floor_pix;
    logic [CB-1:0]            major_inc;
    logic signed [GRAD_W-1:0] quo_ext;
    logic signed [ACC_W-1:0]  grad_ext;
    logic signed [ACC_W-1:0]  acc_base;

    assign in_x0 = i_s_tdata[0 +: CB];
    assign in_y0 = i_s_tdata[CB +: CB];
    assign in_x1 = i_s_tdata[2*CB +: CB];
    assign in_y1 = i_s_tdata[3*CB +: CB];

    assign x_swap    = in_x1 < in_x0;
    assign y_swap    = in_y1 < in_y0;
    assign dx        = x_swap ? in_x0 - in_x1 : in_x1 - in_x0;
    assign dy        = y_swap ? in_y0 - in_y1 : in_y1 - in_y0;
    assign load_axis = (dx == '0) || (dy == '0);
    assign load_xmaj = dy < dx;

    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_s_tready = (r_state == ST_ACCEPT) && out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign div_start    = (r_state == ST_PREP);
    assign div_divisor  = r_major_end - r_major_pos;
    assign div_dividend = (r_minor_end < r_minor_start) ? r_minor_start - r_minor_end
                                                        : r_minor_end - r_minor_start;

    wlr_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign floor_pix = r_acc[FRAC_BITS +: PW];
    assign major_inc = r_major_pos + 1'b1;
    assign quo_ext   = signed'({1'b0, div_quo});
    assign grad_ext  = {{(ACC_W-GRAD_W){r_grad[GRAD_W-1]}}, r_grad};
    assign acc_base  = signed'(ACC_W'({r_minor_start, {FRAC_BITS{1'b0}}}));

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (s_acc) begin
                    if (i_s_tuser == OP_LOAD) begin
                        if (!load_axis) begin
                            n_state = ST_PREP;
                        end
                    end else if (r_phase == PH_MIDDLE && !r_axis) begin
                        n_state = ST_SECOND;
                    end
                end
            end
            ST_PREP:   n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_GRAD;
                end
            end
            ST_GRAD:   n_state = ST_ACC;
            ST_ACC:    n_state = ST_ACCEPT;
            ST_SECOND: begin
                if (out_free) begin
                    n_state = ST_ACCEPT;
                end
            end
            default:   n_state = ST_ACCEPT;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_phase       = r_phase;
        n_x_major     = r_x_major;
        n_axis        = r_axis;
        n_step_down   = r_step_down;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_start = r_minor_start;
        n_minor_end   = r_minor_end;
        n_grad        = r_grad;
        n_acc         = r_acc;
        n_sec_major   = r_sec_major;
        n_sec_minor   = r_sec_minor;
        n_m_tvalid    = r_m_tvalid && !i_m_tready;
        n_px          = r_px;
        n_py          = r_py;
        n_last        = r_last;
        n_done        = r_done;

        case (r_state)
            ST_ACCEPT: begin
                if (s_acc && i_s_tuser == OP_LOAD) begin
                    n_phase = PH_FIRST;
                    n_axis  = load_axis;
                    if (load_axis) begin
                        n_x_major     = (dx != '0);
                        n_major_pos   = (dx != '0) ? in_x0 : in_y0;
                        n_major_end   = (dx != '0) ? in_x1 : in_y1;
                        n_minor_start = (dx != '0) ? in_y0 : in_x0;
                        n_minor_end   = (dx != '0) ? in_y0 : in_x0;
                        n_step_down   = (dx != '0) ? x_swap : y_swap;
                    end else begin
                        n_x_major   = load_xmaj;
                        n_step_down = 1'b0;
                        if (load_xmaj) begin
                            n_major_pos   = x_swap ? in_x1 : in_x0;
                            n_major_end   = x_swap ? in_x0 : in_x1;
                            n_minor_start = x_swap ? in_y1 : in_y0;
                            n_minor_end   = x_swap ? in_y0 : in_y1;
                        end else begin
                            n_major_pos   = y_swap ? in_y1 : in_y0;
                            n_major_end   = y_swap ? in_y0 : in_y1;
                            n_minor_start = y_swap ? in_x1 : in_x0;
                            n_minor_end   = y_swap ? in_x0 : in_x1;
                        end
                    end
                end else if (s_acc && r_phase != PH_IDLE) begin
                    n_m_tvalid = 1'b1;
                    n_last     = 1'b1;
                    n_done     = 1'b0;
                    if (r_axis) begin
                        n_px   = r_x_major ? {1'b0, r_major_pos} : {1'b0, r_minor_start};
                        n_py   = r_x_major ? {1'b0, r_minor_start} : {1'b0, r_major_pos};
                        n_done = (r_major_pos == r_major_end);
                        if (r_major_pos == r_major_end) begin
                            n_phase = PH_IDLE;
                        end else if (r_step_down) begin
                            n_major_pos = r_major_pos - 1'b1;
                        end else begin
                            n_major_pos = major_inc;
                        end
                    end else begin
                        case (r_phase)
                            PH_FIRST: begin
                                n_px = r_x_major ? {1'b0, r_major_pos} : {1'b0, r_minor_start};
                                n_py = r_x_major ? {1'b0, r_minor_start} : {1'b0, r_major_pos};
                                n_major_pos = major_inc;
                                n_phase = (major_inc == r_major_end) ? PH_FINAL : PH_MIDDLE;
                            end
                            PH_MIDDLE: begin
                                n_px   = r_x_major ? {1'b0, r_major_pos} : floor_pix;
                                n_py   = r_x_major ? floor_pix : {1'b0, r_major_pos};
                                n_last = 1'b0;
                                n_sec_major = r_major_pos;
                                n_sec_minor = floor_pix + 1'b1;
                                n_acc       = r_acc + grad_ext;
                                n_major_pos = major_inc;
                                if (major_inc == r_major_end) begin
                                    n_phase = PH_FINAL;
                                end
                            end
                            default: begin
                                n_px   = r_x_major ? {1'b0, r_major_end} : {1'b0, r_minor_end};
                                n_py   = r_x_major ? {1'b0, r_minor_end} : {1'b0, r_major_end};
                                n_done = 1'b1;
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_GRAD: begin
                n_grad = (r_minor_end < r_minor_start) ? -quo_ext : quo_ext;
            end
            ST_ACC: begin
                n_acc = acc_base + grad_ext;
            end
            ST_SECOND: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_px   = r_x_major ? {1'b0, r_sec_major} : r_sec_minor;
                    n_py   = r_x_major ? r_sec_minor : {1'b0, r_sec_major};
                    n_last = 1'b1;
                    n_done = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_phase     <= PH_IDLE;
            r_x_major   <= 1'b0;
            r_axis      <= 1'b0;
            r_step_down <= 1'b0;
            r_m_tvalid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_x_major   <= n_x_major;
            r_axis      <= n_axis;
            r_step_down <= n_step_down;
            r_m_tvalid  <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_major_pos   <= n_major_pos;
        r_major_end   <= n_major_end;
        r_minor_start <= n_minor_start;
        r_minor_end   <= n_minor_end;
        r_grad        <= n_grad;
        r_acc         <= n_acc;
        r_sec_major   <= n_sec_major;
        r_sec_minor   <= n_sec_minor;
        r_px          <= n_px;
        r_py          <= n_py;
        r_last        <= n_last;
        r_done        <= n_done;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OUT_TD_W'({r_py, r_px});
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_done;

    // Divider runs only for sloped lines
    a_div_not_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_axis)
        else $error("divider running on an axis-aligned line");

    // Second pixel follows a middle step only
    a_second_from_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SECOND) && !$past(r_state == ST_SECOND)
            |-> $past(r_phase == PH_MIDDLE) && !r_axis)
        else $error("second pixel outside a middle step");

    // Gradient magnitude never exceeds one
    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> (r_grad <= signed'(GRAD_W'(1) <<< FRAC_BITS))
            && (r_grad >= -(signed'(GRAD_W'(1) <<< FRAC_BITS))))
        else $error("gradient out of range");

endmodule
